### src/indexed_list_engine_top_defines.svh
// Assertion macros for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_TOP_DEFINES_SVH
`define INDEXED_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ile_pkg.sv
// Package: sizes, action codes and status codes of the indexed list engine.
package ile_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [2:0] ACT_PUSH_HEAD = 3'd0;
	localparam logic [2:0] ACT_PUSH_TAIL = 3'd1;
	localparam logic [2:0] ACT_POP_HEAD  = 3'd2;
	localparam logic [2:0] ACT_POP_TAIL  = 3'd3;
	localparam logic [2:0] ACT_INSERT    = 3'd4;
	localparam logic [2:0] ACT_EXTRACT   = 3'd5;
	localparam logic [2:0] ACT_SWAP      = 3'd6;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef logic [VALUE_BITS-1:0] elem_t;

endpackage

### src/indexed_list_engine_top.sv
// Indexed list engine: ordered list of values held in a row of shifting cells.
//
// Use: drive action, value_in, index_a and index_b and raise start; the item
// is taken at a rising edge with start high and busy low. busy never rises, so
// an item may be issued on every cycle.
// Each item gives one result: value_out, status and length, valid for exactly
// one cycle while done is high. The receiver cannot hold results off.
// Flow: the item is registered at the accepting edge, all work is done in
// the following cycle against the cell row, and the result and done are
// registered from that work, with one item per cycle.
// Each cell loads its neighbour, the new value, a swap partner or itself by
// comparing its own position with the action position, so every action,
// shifts included, finishes in that cycle.
// The next item sees the list as left by the one before it.
// Reset clears the element count and the pipeline strobes; cell contents are
// not cleared and only positions below the count ever reach value_out.
module indexed_list_engine_top
	import ile_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         action,
	input  logic signed [31:0] value_in,
	input  logic [4:0]         index_a,
	input  logic [3:0]         index_b,
	output logic               done,
	output logic signed [31:0] value_out,
	output logic [1:0]         status,
	output logic [4:0]         length
);

	`include "indexed_list_engine_top_defines.svh"

	logic               valid_s1;
	logic [2:0]         action_s1;
	logic signed [31:0] value_in_s1;
	logic [4:0]         index_a_s1;
	logic [3:0]         index_b_s1;

	logic [CNT_W-1:0]   count_q;
	elem_t              elem_q [CAPACITY];
	elem_t              elem_d [CAPACITY];
	elem_t              prev_v [CAPACITY];
	elem_t              next_v [CAPACITY];

	logic               ins;
	logic               rem;
	logic               swp;
	logic [1:0]         st;
	logic [CMP_W-1:0]   pos;
	logic [CMP_W-1:0]   ia_w;
	logic [CMP_W-1:0]   ib_w;
	logic [CMP_W-1:0]   cnt_w;
	logic               full;
	elem_t              st_val;
	elem_t              rd_val;
	elem_t              a_val;
	elem_t              b_val;
	logic [CNT_W-1:0]   count_d;
	logic signed [31:0] vout;

	assign busy = 1'b0;

	// item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			action_s1   <= action;
			value_in_s1 <= value_in;
			index_a_s1  <= index_a;
			index_b_s1  <= index_b;
		end
	end

	// decode
	assign ia_w   = CMP_W'(index_a_s1);
	assign ib_w   = CMP_W'(index_b_s1);
	assign cnt_w  = CMP_W'(count_q);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign st_val = VALUE_BITS'(value_in_s1);

	always_comb begin
		ins = 1'b0;
		rem = 1'b0;
		swp = 1'b0;
		st  = ST_IGNORED;
		pos = '0;
		unique case (action_s1) inside
			ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ins = 1'b1;
					st  = ST_DONE;
					pos = (action_s1 == ACT_PUSH_HEAD) ? '0 : cnt_w;
				end
			end
			ACT_POP_HEAD, ACT_POP_TAIL: begin
				if (count_q != '0) begin
					rem = 1'b1;
					st  = ST_DONE;
					pos = (action_s1 == ACT_POP_HEAD) ? '0 : cnt_w - CMP_W'(1);
				end
			end
			ACT_INSERT: begin
				if (ia_w <= cnt_w) begin
					if (full) begin
						st = ST_FULL;
					end else begin
						ins = 1'b1;
						st  = ST_DONE;
						pos = ia_w;
					end
				end
			end
			ACT_EXTRACT: begin
				if (ia_w < cnt_w) begin
					rem = 1'b1;
					st  = ST_DONE;
					pos = ia_w;
				end
			end
			ACT_SWAP: begin
				if (ia_w < cnt_w && ib_w < cnt_w) begin
					swp = 1'b1;
					st  = ST_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// neighbour taps of the cell row
	for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
		if (g == 0) begin : g_first
			assign prev_v[g] = elem_q[g];
		end else begin : g_mid
			assign prev_v[g] = elem_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_v[g] = elem_q[g];
		end else begin : g_inner
			assign next_v[g] = elem_q[g+1];
		end
	end

	assign rd_val = elem_q[pos[IDX_W-1:0]];
	assign a_val  = elem_q[ia_w[IDX_W-1:0]];
	assign b_val  = elem_q[ib_w[IDX_W-1:0]];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			elem_d[i] = elem_q[i];
			if (ins) begin
				if (CMP_W'(i) == pos) begin
					elem_d[i] = st_val;
				end else if (CMP_W'(i) > pos) begin
					elem_d[i] = prev_v[i];
				end
			end else if (rem) begin
				if (CMP_W'(i) >= pos) begin
					elem_d[i] = next_v[i];
				end
			end else if (swp) begin
				if (CMP_W'(i) == ia_w) begin
					elem_d[i] = b_val;
				end else if (CMP_W'(i) == ib_w) begin
					elem_d[i] = a_val;
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign vout = rem ? 32'($signed(rd_val)) : 32'sd0;

	// cell row
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < CAPACITY; i++) begin
				elem_q[i] <= elem_d[i];
			end
		end
	end

	// count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= valid_s1;
			if (valid_s1) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			value_out <= vout;
			status    <= st;
			length    <= 5'(CMP_W'(count_d));
		end
	end

	`ILE_ASSERT_NEXT(a_result_follows, valid_s1, done, "accepted item gave no result")
	`ILE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(CAPACITY),
		"element count above capacity")
	`ILE_ASSERT_NOW(a_reject_no_value, done && status != ST_DONE, value_out == 32'sd0,
		"rejected action returned a value")
	`ILE_ASSERT_NOW(a_reject_holds, done && status != ST_DONE, count_q == $past(count_q),
		"rejected action changed the count")

endmodule

### test/testbench.sv
// Testbench for indexed_list_engine_top: directed and random list actions against a predictor.
module testbench;
	import ile_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int IDLE_MAX = 4;
	localparam int RANDOM_ITEMS = 1260;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [4:0]  length;
	} list_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         action = ACT_PUSH_HEAD;
	logic signed [31:0] value_in = '0;
	logic [4:0]         index_a = '0;
	logic [3:0]         index_b = '0;
	logic               done;
	logic signed [31:0] value_out;
	logic [1:0]         status;
	logic [4:0]         length;

	elem_t        model_cells [CAPACITY];
	int           model_count = 0;
	list_result_t pending_results [$];
	int           error_count = 0;
	bit           idle_on = 1'b1;

	indexed_list_engine_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.value_in  (value_in),
		.index_a   (index_a),
		.index_b   (index_b),
		.done      (done),
		.value_out (value_out),
		.status    (status),
		.length    (length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void open_cell(int pos, elem_t v);
		int i;
		for (i = model_count; i > pos; i--)
			model_cells[i] = model_cells[i-1];
		model_cells[pos] = v;
		model_count++;
	endfunction

	function automatic elem_t close_cell(int pos);
		elem_t v;
		int i;
		v = model_cells[pos];
		for (i = pos; i + 1 < model_count; i++)
			model_cells[i] = model_cells[i+1];
		model_count--;
		return v;
	endfunction

	// Updates the list copy and queues the result this action should give.
	function automatic void apply_list_action(logic [2:0] act, logic signed [31:0] val,
		logic [4:0] ia, logic [3:0] ib);
		list_result_t r;
		elem_t t;
		r.value = '0;
		r.status = ST_IGNORED;
		case (act)
			ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
				if (model_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					open_cell(act == ACT_PUSH_HEAD ? 0 : model_count, val);
					r.status = ST_DONE;
				end
			end
			ACT_POP_HEAD, ACT_POP_TAIL: begin
				if (model_count != 0) begin
					r.value = close_cell(act == ACT_POP_HEAD ? 0 : model_count - 1);
					r.status = ST_DONE;
				end
			end
			ACT_INSERT: begin
				if (int'(ia) <= model_count) begin
					if (model_count >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						open_cell(int'(ia), val);
						r.status = ST_DONE;
					end
				end
			end
			ACT_EXTRACT: begin
				if (int'(ia) < model_count) begin
					r.value = close_cell(int'(ia));
					r.status = ST_DONE;
				end
			end
			ACT_SWAP: begin
				if (int'(ia) < model_count && int'(ib) < model_count) begin
					t = model_cells[ia[3:0]];
					model_cells[ia[3:0]] = model_cells[ib];
					model_cells[ib] = t;
					r.status = ST_DONE;
				end
			end
			default: begin
			end
		endcase
		r.length = model_count[4:0];
		pending_results.push_back(r);
	endfunction

	always @(posedge clk) begin
		list_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result value_out %0d status %0d length %0d",
					$time, value_out, status, length);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (value_out !== e.value) begin
					$display("%0t: value_out expected %0d, got %0d",
						$time, $signed(e.value), value_out);
					error_count++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %0d, got %0d", $time, e.status, status);
					error_count++;
				end
				if (length !== e.length) begin
					$display("%0t: length expected %0d, got %0d", $time, e.length, length);
					error_count++;
				end
			end
		end
	end

	// Called and returns at a falling edge.
	task automatic send_item(input logic [2:0] act, input logic signed [31:0] val,
		input logic [4:0] ia, input logic [3:0] ib);
		int gap;
		gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		value_in <= val;
		index_a <= ia;
		index_b <= ib;
		do @(posedge clk); while (busy !== 1'b0);
		apply_list_action(act, val, ia, ib);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_list();
		send_item(ACT_POP_HEAD, pick_value(), 5'd0, 4'd0);
		send_item(ACT_POP_TAIL, pick_value(), 5'd0, 4'd0);
		send_item(ACT_EXTRACT, pick_value(), 5'd0, 4'd0);
		send_item(ACT_SWAP, pick_value(), 5'd0, 4'd0);
		send_item(ACT_INSERT, pick_value(), 5'd1, 4'd0);
		send_item(ACT_UNUSED, pick_value(), 5'd0, 4'd0);
	endtask

	task automatic test_edge_values();
		send_item(ACT_INSERT, 32'sh8000_0000, 5'd0, 4'd0);
		send_item(ACT_PUSH_TAIL, 32'sh7fff_ffff, 5'd0, 4'd0);
		send_item(ACT_PUSH_HEAD, -32'sd1, 5'd0, 4'd0);
		send_item(ACT_SWAP, 32'sd0, 5'd0, 4'd2);
		send_item(ACT_SWAP, 32'sd0, 5'd1, 4'd1);
		send_item(ACT_INSERT, 32'sd0, 5'd3, 4'd0);
		send_item(ACT_EXTRACT, 32'sd0, 5'd4, 4'd0);
		send_item(ACT_SWAP, 32'sd0, 5'd4, 4'd0);
		send_item(ACT_EXTRACT, 32'sd0, 5'd1, 4'd0);
		send_item(ACT_POP_TAIL, 32'sd0, 5'd0, 4'd0);
		send_item(ACT_POP_HEAD, 32'sd0, 5'd0, 4'd0);
	endtask

	task automatic test_full_list();
		while (model_count < CAPACITY)
			send_item(ACT_INSERT, pick_value(), 5'($urandom_range(0, model_count)), 4'd0);
		send_item(ACT_PUSH_HEAD, pick_value(), 5'd0, 4'd0);
		send_item(ACT_PUSH_TAIL, pick_value(), 5'd0, 4'd0);
		send_item(ACT_INSERT, pick_value(), 5'd16, 4'd0);
		send_item(ACT_INSERT, pick_value(), 5'd17, 4'd0);
		send_item(ACT_INSERT, pick_value(), 5'd31, 4'd15);
		send_item(ACT_SWAP, pick_value(), 5'd15, 4'd0);
		send_item(ACT_SWAP, pick_value(), 5'd0, 4'd15);
		send_item(ACT_EXTRACT, pick_value(), 5'd16, 4'd0);
		send_item(ACT_EXTRACT, pick_value(), 5'd15, 4'd0);
	endtask

	// Long runs of mostly adds or mostly removes so the list swings between empty and full.
	task automatic test_random_traffic(input int n_items);
		bit         growing;
		int         k;
		int         pick;
		int         r;
		logic [2:0] act;
		logic [4:0] ia;
		logic [3:0] ib;
		growing = 1'b1;
		for (k = 0; k < n_items; k++) begin
			if (k % 100 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (model_count >= CAPACITY && $urandom_range(0, 2) == 0)
				growing = 1'b0;
			if (model_count == 0 && $urandom_range(0, 2) == 0)
				growing = 1'b1;
			if ($urandom_range(0, 49) == 0)
				growing = !growing;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				act = ACT_UNUSED;
			end else if (pick < 18) begin
				act = ACT_SWAP;
			end else if ((pick < 68) == growing) begin
				case ($urandom_range(0, 2))
					0: act = ACT_PUSH_HEAD;
					1: act = ACT_PUSH_TAIL;
					default: act = ACT_INSERT;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0: act = ACT_POP_HEAD;
					1: act = ACT_POP_TAIL;
					default: act = ACT_EXTRACT;
				endcase
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				ia = 5'($urandom_range(17, 31));
			else if (r < 4)
				ia = 5'($urandom_range(0, 16));
			else if (act != ACT_INSERT && model_count > 0)
				ia = 5'($urandom_range(0, model_count - 1));
			else
				ia = 5'($urandom_range(0, model_count));
			if ($urandom_range(0, 4) == 0 || model_count == 0)
				ib = 4'($urandom_range(0, 15));
			else
				ib = 4'($urandom_range(0, model_count - 1));
			send_item(act, pick_value(), ia, ib);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_list();
		test_edge_values();
		test_full_list();
		test_random_traffic(RANDOM_ITEMS);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/ile_pkg.sv
src/indexed_list_engine_top.sv
test/testbench.sv
